FILE: rtl/llst_pkg.sv
// llst_pkg: shared types and constants for the leakage level state tracker
// level codes, configuration register indexes, ramp divider widths
// no dependencies
`default_nettype none

package llst_pkg;

  // leakage level codes as seen on the result channel
  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_WATCH    = 2'd1,
    LVL_FAULT    = 2'd2,
    LVL_RESTORED = 2'd3
  } lvl_t;

  // configuration register indexes
  localparam logic CFG_TRIP  = 1'b0;
  localparam logic CFG_WATCH = 1'b1;

  localparam int CUR_W  = 16;              // current sample width
  localparam int TIME_W = 32;              // timestamp width
  localparam int DVD_W  = 26;              // |diff| * 1000 fits in 26 bits
  localparam int RAMP_W = 27;              // signed ramp rate width
  localparam int CNT_W  = 5;               // divider step counter width

  localparam logic [CUR_W-1:0] TRIP_RST  = 16'd300;
  localparam logic [CUR_W-1:0] WATCH_RST = 16'd150;
  localparam logic [9:0]       RATE_SCALE = 10'd1000;   // ms to s

endpackage

`default_nettype wire

FILE: rtl/leakage_level_state_tracker_core.sv
// leakage_level_state_tracker_core: hysteresis level tracker with ramp rate, uses llst_pkg
// one shared restoring divider stepped by a small sequencer; in_ready only in idle
// per input transfer: scale, 26 divide steps, load; divide steps are skipped when the ramp
// is forced to zero (first sample, time not advancing); a new input is taken only once
//   the last result is loaded, and a full output register stalls load and input
// synchronous active-low reset: level normal, history cleared, trip 300, watch 150
`default_nettype none

module leakage_level_state_tracker_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration
  input  wire                                  cfg_we,
  input  wire                                  cfg_index,
  input  wire [llst_pkg::CUR_W-1:0]            cfg_wdata,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire [llst_pkg::CUR_W-1:0]            in_ac_current,
  input  wire [llst_pkg::TIME_W-1:0]           in_sample_time,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [1:0]                           out_leak_level,
  output logic                                 out_fault_flag,
  output logic signed [llst_pkg::RAMP_W-1:0]   out_ramp_rate,
  output logic [llst_pkg::TIME_W-1:0]          out_onset_time
);

  import llst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // control state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CUR_W-1:0]     trip_r, trip_nxt;
  logic [CUR_W-1:0]     watch_r, watch_nxt;
  lvl_t                 lvl_r, lvl_nxt;
  logic [TIME_W-1:0]    onset_r, onset_nxt;
  logic [CUR_W-1:0]     prev_cur_r, prev_cur_nxt;
  logic [TIME_W-1:0]    prev_time_r, prev_time_nxt;
  logic                 has_prev_r, has_prev_nxt;

  // datapath registers
  logic [CUR_W-1:0]     mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;
  logic [TIME_W-1:0]    dt_r, dt_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [1:0]           o_lvl_r, o_lvl_nxt;
  logic                 o_fault_r, o_fault_nxt;
  logic [RAMP_W-1:0]    o_ramp_r, o_ramp_nxt;
  logic [TIME_W-1:0]    o_onset_r, o_onset_nxt;

  logic                 in_xfer;
  logic                 out_free;
  logic [CUR_W:0]       diff;
  logic [CUR_W+2:0]     ac_x5;
  logic [CUR_W+1:0]     watch_x4;
  logic                 below_rel;
  lvl_t                 lvl_new;
  logic [CUR_W+9:0]     prod;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      trial_sub;
  logic                 ge;
  logic [RAMP_W-1:0]    q_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_leak_level = o_lvl_r;
  assign out_fault_flag = o_fault_r;
  assign out_ramp_rate  = o_ramp_r;
  assign out_onset_time = o_onset_r;

  // level classification with release band at four fifths of watch
  always_comb begin
    ac_x5     = {3'b000, in_ac_current} + {1'b0, in_ac_current, 2'b00};
    watch_x4  = {watch_r, 2'b00};
    below_rel = ac_x5 < {1'b0, watch_x4};
    if (in_ac_current >= trip_r) begin
      lvl_new = LVL_FAULT;
    end else if (in_ac_current >= watch_r) begin
      lvl_new = LVL_WATCH;
    end else if (below_rel) begin
      lvl_new = (lvl_r == LVL_FAULT || lvl_r == LVL_WATCH) ? LVL_RESTORED : LVL_NORMAL;
    end else begin
      lvl_new = lvl_r;
    end
  end

  // signed current change and shared divider step
  always_comb begin
    diff      = {1'b0, in_ac_current} - {1'b0, prev_cur_r};
    prod      = mag_r * RATE_SCALE;
    trial     = {rem_r, dvd_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dt_r};
    ge        = ~trial_sub[TIME_W];
    q_ext     = {1'b0, dvd_r};
  end

  // sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    trip_nxt      = trip_r;
    watch_nxt     = watch_r;
    lvl_nxt       = lvl_r;
    onset_nxt     = onset_r;
    prev_cur_nxt  = prev_cur_r;
    prev_time_nxt = prev_time_r;
    has_prev_nxt  = has_prev_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    dt_nxt        = dt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    o_lvl_nxt     = o_lvl_r;
    o_fault_nxt   = o_fault_r;
    o_ramp_nxt    = o_ramp_r;
    o_onset_nxt   = o_onset_r;

    // result transfer frees the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_TRIP) begin
        trip_nxt = cfg_wdata;
      end else begin
        watch_nxt = cfg_wdata;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // level and onset update, history capture
          lvl_nxt = lvl_new;
          if (lvl_new == LVL_NORMAL) begin
            onset_nxt = '0;
          end else if (lvl_r == LVL_NORMAL) begin
            onset_nxt = in_sample_time;
          end
          neg_nxt       = diff[CUR_W];
          mag_nxt       = diff[CUR_W] ? CUR_W'(-diff) : diff[CUR_W-1:0];
          dt_nxt        = in_sample_time - prev_time_r;
          zero_nxt      = ~has_prev_r | (in_sample_time <= prev_time_r);
          prev_cur_nxt  = in_ac_current;
          prev_time_nxt = in_sample_time;
          has_prev_nxt  = 1'b1;
          state_nxt     = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // scale to per-second units, then divide unless rate is zero
        dvd_nxt = zero_r ? '0 : prod[DVD_W-1:0];
        rem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = zero_r ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // one restoring step: quotient bit shifts in from the right
        rem_nxt = ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // load the output register once it is free
        if (out_free) begin
          o_lvl_nxt     = lvl_r;
          o_fault_nxt   = (lvl_r == LVL_FAULT);
          o_ramp_nxt    = neg_r ? -q_ext : q_ext;
          o_onset_nxt   = onset_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      trip_r      <= TRIP_RST;
      watch_r     <= WATCH_RST;
      lvl_r       <= LVL_NORMAL;
      onset_r     <= '0;
      prev_cur_r  <= '0;
      prev_time_r <= '0;
      has_prev_r  <= 1'b0;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      zero_r      <= 1'b0;
      dt_r        <= '0;
      dvd_r       <= '0;
      rem_r       <= '0;
      o_lvl_r     <= '0;
      o_fault_r   <= 1'b0;
      o_ramp_r    <= '0;
      o_onset_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      trip_r      <= trip_nxt;
      watch_r     <= watch_nxt;
      lvl_r       <= lvl_nxt;
      onset_r     <= onset_nxt;
      prev_cur_r  <= prev_cur_nxt;
      prev_time_r <= prev_time_nxt;
      has_prev_r  <= has_prev_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      zero_r      <= zero_nxt;
      dt_r        <= dt_nxt;
      dvd_r       <= dvd_nxt;
      rem_r       <= rem_nxt;
      o_lvl_r     <= o_lvl_nxt;
      o_fault_r   <= o_fault_nxt;
      o_ramp_r    <= o_ramp_nxt;
      o_onset_r   <= o_onset_nxt;
    end
  end

endmodule

`default_nettype wire
